// File: sv/kbse_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kbse_pkg
// Types and constants shared by the keyboard scancode encoder.
// ----------------------------------------------------------------------------
package kbse_pkg;

   localparam logic CMD_KEY   = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   localparam logic [3:0] CSR_AUTO_REPEAT = 4'd0;
   localparam logic [3:0] CSR_LOCK_STYLE  = 4'd1;
   localparam logic [3:0] CSR_EUC_OUTPUT  = 4'd2;
   localparam logic [3:0] CSR_JP_LAYOUT   = 4'd3;

   localparam int FL_NOREPT = 0;
   localparam int FL_PUSHSH = 1;
   localparam int FL_TOGSH  = 2;
   localparam int FL_ALTFN  = 3;
   localparam int FL_PROGFN = 4;
   localparam int FL_A      = 5;
   localparam int FL_C      = 6;
   localparam int FL_G      = 7;
   localparam int FL_J      = 8;
   localparam int FL_K      = 9;
   localparam int FL_S      = 10;
   localparam int FL_N      = 11;
   localparam int FL_CAPLK  = 12;

   localparam int MS_CTRL   = 0;
   localparam int MS_RSHIFT = 1;
   localparam int MS_LSHIFT = 2;
   localparam int MS_ALT    = 3;
   localparam int MS_CAPS   = 4;
   localparam int MS_KANA   = 5;
   localparam int MS_ALTGR  = 6;

   localparam logic [7:0] SK_CTRL   = 8'd0;
   localparam logic [7:0] SK_RSHIFT = 8'd1;
   localparam logic [7:0] SK_LSHIFT = 8'd2;
   localparam logic [7:0] SK_ALT    = 8'd3;
   localparam logic [7:0] SK_CAPS   = 8'd4;
   localparam logic [7:0] SK_ALNUM  = 8'd5;
   localparam logic [7:0] SK_KANA   = 8'd6;
   localparam logic [7:0] SK_ALTGR  = 8'd7;

   localparam logic [1:0] LK_NONE   = 2'd0;
   localparam logic [1:0] LK_CAPS   = 2'd1;
   localparam logic [1:0] LK_SHIFT  = 2'd2;
   localparam logic [1:0] LK_SHIFT2 = 2'd3;

   localparam logic [7:0] BYTE_SS2     = 8'h8e;
   localparam logic [7:0] KANA_LOW     = 8'ha1;
   localparam logic [7:0] KANA_HIGH    = 8'hdf;
   localparam logic [6:0] KEY_IDX_MASK = 7'h7f;

   typedef struct packed {
      logic [12:0] flags;
      logic [7:0]  nrm;
      logic [7:0]  shf;
      logic [7:0]  ctl;
      logic [7:0]  alt;
      logic [7:0]  kan;
      logic [7:0]  ksh;
   } entry_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
      logic       function_key;
      logic       shift_held;
   } rsp_type;

endpackage
`default_nettype wire

// File: sv/kbse_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kbse_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kbse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// File: sv/keyboard_scancode_encoder_top.sv
`default_nettype none
// A key event's entry is read from registered RAM into the execute stage.
// Throughput: one item per cycle while results drain; the two-entry result
// queue and its single output port set the rate, so an EUC kana key (two
// bytes) can hold back the next item under back-to-back load.
// Reset: modifiers, lock kind and key-down state clear at once (valid bits);
// key table contents are undefined until written.
// ----------------------------------------------------------------------------
// keyboard_scancode_encoder_top
// Key event to character byte translator with a loadable key table.
// ----------------------------------------------------------------------------
module keyboard_scancode_encoder_top
   import kbse_pkg::*;
#(
   parameter int NUM_KEYS = 128
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_cmd,
   input  wire logic [7:0]  req_key_code,
   input  wire logic [12:0] req_entry_flags,
   input  wire logic [7:0]  req_normal_byte,
   input  wire logic [7:0]  req_shifted_byte,
   input  wire logic [7:0]  req_control_byte,
   input  wire logic [7:0]  req_alternate_byte,
   input  wire logic [7:0]  req_kana_byte,
   input  wire logic [7:0]  req_kana_shifted_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last_byte,
   output logic             rsp_function_key,
   output logic             rsp_shift_held,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [3:0]  csr_index,
   input  wire logic [7:0]  csr_wdata
);

   localparam int         IDX_W    = $clog2(NUM_KEYS);
   localparam int         ENTRY_W  = $bits(entry_type);
   localparam logic [7:0] KEYS_LIM = 8'(NUM_KEYS);

   logic       auto_repeat_ff;
   logic [1:0] lock_style_ff;
   logic       euc_ff;
   logic       jp_ff;

   logic             csr_write;
   logic             req_accept;
   logic [6:0]       req_idx;
   logic             in_range;
   logic             tbl_we;
   logic             rd_en;
   entry_type        w_entry;
   logic [ENTRY_W-1:0] tbl_rdata;
   logic             down_rdata;
   entry_type        e;

   logic             s1_vld_ff, s1_vld_in;
   logic [7:0]       s1_code_ff;
   logic [IDX_W-1:0] s1_addr;
   logic             s1_fire;

   logic [NUM_KEYS-1:0] down_vld_ff;
   logic             fwd_vld_ff;
   logic [IDX_W-1:0] fwd_addr_ff;
   logic             fwd_data_ff;

   logic [6:0]       mods_ff, mods_in;
   logic [1:0]       lock_ff, lock_in;

   logic             release_k, push, down, drop, is_shift, is_fn, sh;
   logic             nk_hit, nk_kana, two;
   logic [7:0]       nk_byte;
   logic [1:0]       s1_cnt;
   rsp_type          r0, r1;

   rsp_type          q_ff [2];
   logic             q_rd_ff, q_rd_in;
   logic [1:0]       q_cnt_ff, q_cnt_in;
   logic             wr_ptr, pop;
   rsp_type          q_head;

   // configuration
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         auto_repeat_ff <= 1'b1;
         lock_style_ff  <= LK_NONE;
         euc_ff         <= 1'b0;
         jp_ff          <= 1'b0;
      end else if (csr_write) begin
         if (csr_index == CSR_AUTO_REPEAT) auto_repeat_ff <= csr_wdata[0];
         if (csr_index == CSR_LOCK_STYLE)  lock_style_ff  <= csr_wdata[1:0];
         if (csr_index == CSR_EUC_OUTPUT)  euc_ff         <= csr_wdata[0];
         if (csr_index == CSR_JP_LAYOUT)   jp_ff          <= csr_wdata[0];
      end
   end

   // input transfer and memory access
   assign req_accept = req_valid && !req_stall;
   assign req_idx    = req_key_code[6:0] & KEY_IDX_MASK;
   assign in_range   = {1'b0, req_idx} < KEYS_LIM;
   assign tbl_we     = req_accept && (req_cmd == CMD_WRITE) && in_range;
   assign rd_en      = req_accept && (req_cmd == CMD_KEY) && in_range;
   assign req_stall  = s1_vld_ff && !s1_fire;

   assign w_entry = '{flags: req_entry_flags, nrm: req_normal_byte,
                      shf: req_shifted_byte, ctl: req_control_byte,
                      alt: req_alternate_byte, kan: req_kana_byte,
                      ksh: req_kana_shifted_byte};

   kbse_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_KEYS)) u_table (
      .clock (clock),
      .we    (tbl_we),
      .waddr (req_idx[IDX_W-1:0]),
      .wdata (w_entry),
      .re    (rd_en),
      .raddr (req_idx[IDX_W-1:0]),
      .rdata (tbl_rdata)
   );

   kbse_ram #(.WIDTH(1), .DEPTH(NUM_KEYS)) u_down (
      .clock (clock),
      .we    (s1_fire),
      .waddr (s1_addr),
      .wdata (push),
      .re    (rd_en),
      .raddr (req_idx[IDX_W-1:0]),
      .rdata (down_rdata)
   );

   assign e = entry_type'(tbl_rdata);

   // execute stage
   assign s1_vld_in = rd_en || (s1_vld_ff && !s1_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         s1_code_ff <= req_key_code;
      end
   end

   assign s1_addr = s1_code_ff[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         down_vld_ff <= '0;
         fwd_vld_ff  <= 1'b0;
      end else if (s1_fire) begin
         down_vld_ff[s1_addr] <= 1'b1;
         fwd_vld_ff           <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         fwd_addr_ff <= s1_addr;
         fwd_data_ff <= push;
      end
   end

   assign release_k = s1_code_ff[7];
   assign push      = !release_k;
   assign down      = (fwd_vld_ff && fwd_addr_ff == s1_addr) ? fwd_data_ff :
                      (down_vld_ff[s1_addr] && down_rdata);
   assign drop      = push && down && (!auto_repeat_ff || e.flags[FL_NOREPT]);
   assign is_shift  = e.flags[FL_PUSHSH] || e.flags[FL_TOGSH];
   assign is_fn     = (e.flags[FL_ALTFN] && mods_ff[MS_ALT]) || e.flags[FL_PROGFN];
   assign sh        = mods_ff[MS_RSHIFT] || mods_ff[MS_LSHIFT];

   always_comb begin
      mods_in = mods_ff;
      lock_in = lock_ff;
      if (s1_fire && !drop && is_shift) begin
         unique case (e.nrm)
            SK_CTRL:   mods_in[MS_CTRL]   = push;
            SK_RSHIFT: mods_in[MS_RSHIFT] = push;
            SK_LSHIFT: mods_in[MS_LSHIFT] = push;
            SK_ALT:    mods_in[MS_ALT]    = push;
            SK_CAPS: begin
               if (push) begin
                  mods_in[MS_CAPS] = !mods_ff[MS_CAPS];
                  lock_in = (lock_style_ff != LK_NONE) ? lock_style_ff : LK_CAPS;
               end
            end
            SK_ALNUM: begin
               if (push) mods_in[MS_KANA] = 1'b0;
            end
            SK_KANA: begin
               if (push && jp_ff) mods_in[MS_KANA] = 1'b1;
            end
            SK_ALTGR:  mods_in[MS_ALTGR]  = push;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mods_ff <= '0;
         lock_ff <= LK_NONE;
      end else begin
         mods_ff <= mods_in;
         lock_ff <= lock_in;
      end
   end

   // byte selection by modifier priority
   always_comb begin
      nk_hit  = 1'b0;
      nk_byte = e.nrm;
      nk_kana = 1'b0;
      if (mods_ff[MS_ALT]) begin
         nk_hit  = e.flags[FL_A];
         nk_byte = e.alt;
      end else if (mods_ff[MS_CTRL]) begin
         nk_hit  = e.flags[FL_C];
         nk_byte = e.ctl;
      end else if (mods_ff[MS_ALTGR]) begin
         nk_hit  = e.flags[FL_G];
         nk_byte = e.kan;
      end else if (mods_ff[MS_KANA]) begin
         nk_kana = 1'b1;
         nk_hit  = sh ? e.flags[FL_J] : e.flags[FL_K];
         nk_byte = sh ? e.ksh : e.kan;
      end else if (mods_ff[MS_CAPS] && ((sh && e.flags[FL_S]) || e.flags[FL_N])) begin
         if (sh && e.flags[FL_S]) begin
            if (e.flags[FL_CAPLK]) begin
               nk_hit  = (lock_ff != LK_NONE);
               nk_byte = (lock_ff == LK_CAPS) ? e.shf : e.nrm;
            end else begin
               nk_hit  = (lock_ff != LK_NONE);
               nk_byte = (lock_ff == LK_SHIFT2) ? e.nrm : e.shf;
            end
         end else begin
            if (e.flags[FL_CAPLK]) begin
               nk_hit  = 1'b1;
               nk_byte = e.shf;
            end else begin
               nk_hit  = (lock_ff != LK_NONE);
               nk_byte = (lock_ff == LK_SHIFT2) ? e.shf : e.nrm;
            end
         end
      end else if (sh) begin
         nk_hit  = e.flags[FL_S];
         nk_byte = e.shf;
      end else begin
         nk_hit  = e.flags[FL_N];
         nk_byte = e.nrm;
      end
   end

   assign two = nk_kana && euc_ff && (nk_byte >= KANA_LOW) && (nk_byte <= KANA_HIGH);

   always_comb begin
      s1_cnt = 2'd0;
      r0     = '0;
      r1     = '0;
      if (!drop && !is_shift && push) begin
         if (is_fn) begin
            s1_cnt = 2'd1;
            r0 = '{out_byte: {1'b0, s1_code_ff[6:0]}, last_byte: 1'b1,
                   function_key: 1'b1, shift_held: sh};
         end else if (nk_hit) begin
            if (two) begin
               s1_cnt = 2'd2;
               r0 = '{out_byte: BYTE_SS2, last_byte: 1'b0,
                      function_key: 1'b0, shift_held: 1'b0};
               r1 = '{out_byte: nk_byte, last_byte: 1'b1,
                      function_key: 1'b0, shift_held: 1'b0};
            end else begin
               s1_cnt = 2'd1;
               r0 = '{out_byte: nk_byte, last_byte: 1'b1,
                      function_key: 1'b0, shift_held: 1'b0};
            end
         end
      end
   end

   // result queue
   assign pop     = rsp_valid && !rsp_stall;
   assign s1_fire = s1_vld_ff && ((3'(s1_cnt) + 3'(q_cnt_ff)) <= (3'd2 + 3'(pop)));
   assign wr_ptr  = q_rd_ff ^ q_cnt_ff[0];

   always_ff @(posedge clock) begin
      if (s1_fire && s1_cnt != 2'd0) begin
         q_ff[wr_ptr] <= r0;
      end
      if (s1_fire && s1_cnt == 2'd2) begin
         q_ff[!wr_ptr] <= r1;
      end
   end

   assign q_rd_in  = q_rd_ff ^ pop;
   assign q_cnt_in = q_cnt_ff + (s1_fire ? s1_cnt : 2'd0) - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         q_rd_ff  <= 1'b0;
         q_cnt_ff <= 2'd0;
      end else begin
         q_rd_ff  <= q_rd_in;
         q_cnt_ff <= q_cnt_in;
      end
   end

   assign q_head           = q_ff[q_rd_ff];
   assign rsp_valid        = (q_cnt_ff != 2'd0);
   assign rsp_out_byte     = q_head.out_byte;
   assign rsp_last_byte    = q_head.last_byte;
   assign rsp_function_key = q_head.function_key;
   assign rsp_shift_held   = q_head.shift_held;

endmodule
`default_nettype wire

// File: tb/keyboard_scancode_encoder_top_tb.sv
// ----------------------------------------------------------------------------
// keyboard_scancode_encoder_top_tb
// Self-checking bench for the scancode encoder. Key table writes and key
// press/release events stream in with random gaps and random result stalls.
// A behavioral translator tracks held keys, modifiers and lock kind and
// queues the character bytes each event should produce; every result
// transfer is compared field by field against that queue. Register settings
// change between phases once the block has drained.
// ----------------------------------------------------------------------------
module keyboard_scancode_encoder_top_tb
   import kbse_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_KEYS       = 128;
   localparam int HALF_PERIOD    = 5;
   localparam int DRAIN_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = 136;

   typedef struct packed {
      logic        cmd;
      logic [7:0]  key_code;
      logic [12:0] flags;
      logic [7:0]  nrm;
      logic [7:0]  shf;
      logic [7:0]  ctl;
      logic [7:0]  alt;
      logic [7:0]  kan;
      logic [7:0]  ksh;
   } key_request_type;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last_byte;
   logic        rsp_function_key;
   logic        rsp_shift_held;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_index = '0;
   logic [7:0]  csr_wdata = '0;

   key_request_type req_item = '0;

   // translator state
   entry_type  key_map [NUM_KEYS];
   bit         key_held [NUM_KEYS];
   logic [6:0] modifiers = '0;
   logic [1:0] lock_mode = LK_NONE;
   bit         cfg_repeat = 1'b1;
   logic [1:0] cfg_lock_style = LK_NONE;
   bit         cfg_euc = 1'b0;
   bit         cfg_jp = 1'b0;

   rsp_type         expected_chars [$];
   key_request_type pending_requests [$];

   // stimulus-side view of the table
   bit          gen_written [NUM_KEYS];
   logic [12:0] gen_flags [NUM_KEYS];
   int          written_keys [$];

   int send_gap = 0;
   int send_calm = 0;
   int stall_left = 0;
   int recv_calm = 0;
   int quiet_cycles = 0;
   int mismatch_count = 0;
   int results_checked = 0;
   int requests_sent = 0;
   int table_writes = 0;
   int settings_used = 0;

   always #HALF_PERIOD clock = ~clock;

   keyboard_scancode_encoder_top #(
      .NUM_KEYS(NUM_KEYS)
   ) u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_cmd               (req_item.cmd),
      .req_key_code          (req_item.key_code),
      .req_entry_flags       (req_item.flags),
      .req_normal_byte       (req_item.nrm),
      .req_shifted_byte      (req_item.shf),
      .req_control_byte      (req_item.ctl),
      .req_alternate_byte    (req_item.alt),
      .req_kana_byte         (req_item.kan),
      .req_kana_shifted_byte (req_item.ksh),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_out_byte          (rsp_out_byte),
      .rsp_last_byte         (rsp_last_byte),
      .rsp_function_key      (rsp_function_key),
      .rsp_shift_held        (rsp_shift_held),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   function automatic int pick_gap(inout int calm_left);
      int r;
      r = $urandom_range(0, 99);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if (r < 3) begin
         calm_left = $urandom_range(30, 150);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [12:0] flag_bit(int pos);
      return 13'b1 << pos;
   endfunction

   function automatic void add_char(logic [7:0] b);
      expected_chars.push_back('{b, 1'b1, 1'b0, 1'b0});
   endfunction

   function automatic void add_kana(logic [7:0] b);
      if (cfg_euc && b >= KANA_LOW && b <= KANA_HIGH) begin
         expected_chars.push_back('{BYTE_SS2, 1'b0, 1'b0, 1'b0});
      end
      add_char(b);
   endfunction

   function automatic void apply_shift_key(entry_type e, bit push);
      case (e.nrm)
         SK_CTRL:   modifiers[MS_CTRL] = push;
         SK_RSHIFT: modifiers[MS_RSHIFT] = push;
         SK_LSHIFT: modifiers[MS_LSHIFT] = push;
         SK_ALT:    modifiers[MS_ALT] = push;
         SK_CAPS: begin
            if (push) begin
               modifiers[MS_CAPS] = ~modifiers[MS_CAPS];
               lock_mode = (cfg_lock_style != LK_NONE) ? cfg_lock_style : LK_CAPS;
            end
         end
         SK_ALNUM: begin
            if (push) modifiers[MS_KANA] = 1'b0;
         end
         SK_KANA: begin
            if (push && cfg_jp) modifiers[MS_KANA] = 1'b1;
         end
         SK_ALTGR:  modifiers[MS_ALTGR] = push;
         default: ;
      endcase
   endfunction

   function automatic void translate_char_key(entry_type e);
      logic [12:0] f;
      logic        sh;
      f = e.flags;
      sh = modifiers[MS_RSHIFT] | modifiers[MS_LSHIFT];
      if (modifiers[MS_ALT]) begin
         if (f[FL_A]) add_char(e.alt);
      end else if (modifiers[MS_CTRL]) begin
         if (f[FL_C]) add_char(e.ctl);
      end else if (modifiers[MS_ALTGR]) begin
         if (f[FL_G]) add_char(e.kan);
      end else if (modifiers[MS_KANA]) begin
         if (sh) begin
            if (f[FL_J]) add_kana(e.ksh);
         end else if (f[FL_K]) begin
            add_kana(e.kan);
         end
      end else if (modifiers[MS_CAPS] && sh && f[FL_S]) begin
         if (f[FL_CAPLK]) begin
            if (lock_mode == LK_CAPS) add_char(e.shf);
            else if (lock_mode != LK_NONE) add_char(e.nrm);
         end else if (lock_mode == LK_CAPS || lock_mode == LK_SHIFT) begin
            add_char(e.shf);
         end else if (lock_mode == LK_SHIFT2) begin
            add_char(e.nrm);
         end
      end else if (modifiers[MS_CAPS] && f[FL_N]) begin
         if (f[FL_CAPLK]) add_char(e.shf);
         else if (lock_mode == LK_CAPS || lock_mode == LK_SHIFT) add_char(e.nrm);
         else if (lock_mode == LK_SHIFT2) add_char(e.shf);
      end else if (sh) begin
         if (f[FL_S]) add_char(e.shf);
      end else if (f[FL_N]) begin
         add_char(e.nrm);
      end
   endfunction

   function automatic void translate_request(key_request_type r);
      logic [6:0] idx;
      logic       rel;
      entry_type  e;
      idx = r.key_code[6:0];
      rel = r.key_code[7];
      if (r.cmd == CMD_WRITE) begin
         key_map[idx] = '{r.flags, r.nrm, r.shf, r.ctl, r.alt, r.kan, r.ksh};
         return;
      end
      e = key_map[idx];
      if (rel) begin
         key_held[idx] = 1'b0;
      end else if (key_held[idx] && (!cfg_repeat || e.flags[FL_NOREPT])) begin
         return;
      end else begin
         key_held[idx] = 1'b1;
      end
      if (e.flags[FL_PUSHSH] || e.flags[FL_TOGSH]) begin
         apply_shift_key(e, !rel);
         return;
      end
      if ((e.flags[FL_ALTFN] && modifiers[MS_ALT]) || e.flags[FL_PROGFN]) begin
         if (!rel) begin
            expected_chars.push_back('{{1'b0, idx}, 1'b1, 1'b1,
                                       modifiers[MS_RSHIFT] | modifiers[MS_LSHIFT]});
         end
         return;
      end
      if (!rel) translate_char_key(e);
   endfunction

   function automatic key_request_type random_request();
      key_request_type r;
      r.cmd      = 1'($urandom_range(0, 1));
      r.key_code = 8'($urandom_range(0, 255));
      r.flags    = 13'($urandom_range(0, 8191));
      r.nrm      = 8'($urandom_range(0, 255));
      r.shf      = 8'($urandom_range(0, 255));
      r.ctl      = 8'($urandom_range(0, 255));
      r.alt      = 8'($urandom_range(0, 255));
      r.kan      = 8'($urandom_range(0, 255));
      r.ksh      = 8'($urandom_range(0, 255));
      return r;
   endfunction

   task automatic queue_entry(logic [7:0] code, logic [12:0] flags, logic [7:0] nrm,
                              logic [7:0] shf, logic [7:0] ctl, logic [7:0] alt,
                              logic [7:0] kan, logic [7:0] ksh);
      key_request_type r;
      r = '{CMD_WRITE, code, flags, nrm, shf, ctl, alt, kan, ksh};
      if (!gen_written[code[6:0]]) begin
         gen_written[code[6:0]] = 1'b1;
         written_keys.push_back(int'(code[6:0]));
      end
      gen_flags[code[6:0]] = flags;
      pending_requests.push_back(r);
      table_writes++;
   endtask

   task automatic queue_key(logic [7:0] code);
      key_request_type r;
      r = random_request();
      r.cmd = CMD_KEY;
      r.key_code = code;
      pending_requests.push_back(r);
   endtask

   task automatic queue_random_entry();
      key_request_type r;
      int pick;
      logic [7:0] code;
      r = random_request();
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
         if ($urandom_range(0, 1)) r.flags[FL_PUSHSH] = 1'b1;
         else r.flags[FL_TOGSH] = 1'b1;
         if ($urandom_range(0, 9) != 0) r.nrm = 8'($urandom_range(0, 7));
      end else if (pick < 95) begin
         r.flags[FL_PUSHSH] = 1'b0;
         r.flags[FL_TOGSH] = 1'b0;
         if (pick < 35) begin
            r.flags[FL_PROGFN] = 1'b1;
         end else begin
            r.flags[FL_PROGFN] = 1'b0;
            if (pick < 45) r.flags[FL_ALTFN] = 1'b1;
            if ($urandom_range(0, 9) != 0) begin
               r.flags[FL_N] = 1'b1;
               r.flags[FL_S] = 1'b1;
            end
         end
      end
      if ($urandom_range(0, 1)) r.kan = 8'($urandom_range(KANA_LOW - 1, KANA_HIGH + 1));
      if ($urandom_range(0, 1)) r.ksh = 8'($urandom_range(KANA_LOW - 1, KANA_HIGH + 1));
      code = r.key_code;
      if ($urandom_range(0, 99) < 30) begin
         code[6:0] = 7'(written_keys[$urandom_range(0, written_keys.size() - 1)]);
      end
      queue_entry(code, r.flags, r.nrm, r.shf, r.ctl, r.alt, r.kan, r.ksh);
   endtask

   task automatic queue_random_event();
      int pool [$];
      int idx;
      bit shifty;
      if ($urandom_range(0, 99) < 30) begin
         foreach (written_keys[i]) begin
            if (gen_flags[written_keys[i]][FL_PUSHSH] || gen_flags[written_keys[i]][FL_TOGSH])
               pool.push_back(written_keys[i]);
         end
      end
      if (pool.size() == 0) pool = written_keys;
      idx = pool[$urandom_range(0, pool.size() - 1)];
      shifty = gen_flags[idx][FL_PUSHSH] | gen_flags[idx][FL_TOGSH];
      queue_key({($urandom_range(0, 99) < (shifty ? 55 : 35)) ? 1'b1 : 1'b0, 7'(idx)});
   endtask

   task automatic write_register(logic [3:0] index, logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_AUTO_REPEAT: cfg_repeat = value[0];
         CSR_LOCK_STYLE:  cfg_lock_style = value[1:0];
         CSR_EUC_OUTPUT:  cfg_euc = value[0];
         CSR_JP_LAYOUT:   cfg_jp = value[0];
         default: ;
      endcase
   endtask

   task automatic program_registers(bit repeat_on, logic [1:0] style, bit euc, bit jp);
      write_register(CSR_AUTO_REPEAT, {7'b0, repeat_on});
      write_register(CSR_LOCK_STYLE, {6'b0, style});
      write_register(CSR_EUC_OUTPUT, {7'b0, euc});
      write_register(CSR_JP_LAYOUT, {7'b0, jp});
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic settle();
      while (pending_requests.size() != 0 || req_valid || expected_chars.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      mismatch_count++;
      if (mismatch_count <= 40)
         $display("%0t: %s mismatch at result %0d: got %02h, expected %02h",
                  $time, what, results_checked, got, want);
   endtask

   // driver: hold payload while stalled, advance on transfer
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            translate_request(req_item);
            requests_sent++;
            send_gap = pick_gap(send_calm);
         end
         if (!(req_valid && req_stall)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
               req_item <= pending_requests.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin : result_check
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_chars.size() == 0) begin
               report_mismatch("unexpected result", rsp_out_byte, 8'h00);
            end else begin
               want = expected_chars.pop_front();
               if (rsp_out_byte !== want.out_byte)
                  report_mismatch("out_byte", rsp_out_byte, want.out_byte);
               if (rsp_last_byte !== want.last_byte)
                  report_mismatch("last_byte", {7'b0, rsp_last_byte}, {7'b0, want.last_byte});
               if (rsp_function_key !== want.function_key)
                  report_mismatch("function_key", {7'b0, rsp_function_key},
                                  {7'b0, want.function_key});
               if (rsp_shift_held !== want.shift_held)
                  report_mismatch("shift_held", {7'b0, rsp_shift_held}, {7'b0, want.shift_held});
            end
            results_checked++;
         end
         if (stall_left == 0) stall_left = pick_gap(recv_calm);
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("No transfer for %0d cycles with %0d requests queued, %0d results owed",
                  quiet_cycles, pending_requests.size(), expected_chars.size());
         $display("FAIL keyboard_scancode_encoder_top");
         $finish;
      end
   end

   initial begin
      logic [12:0] char_flags;
      char_flags = flag_bit(FL_N) | flag_bit(FL_S) | flag_bit(FL_C) | flag_bit(FL_A) |
                   flag_bit(FL_G) | flag_bit(FL_K) | flag_bit(FL_J);
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset register values
      queue_entry(8'h00, char_flags, 8'h61, 8'h41, 8'h01, 8'he1, 8'hb1, 8'hdf);
      queue_entry(8'hff, flag_bit(FL_PUSHSH), SK_LSHIFT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      queue_entry(8'h10, flag_bit(FL_TOGSH), SK_CAPS, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      queue_entry(8'h11, flag_bit(FL_PROGFN), 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
      queue_entry(8'h20, flag_bit(FL_PUSHSH), SK_ALT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      queue_entry(8'h21, flag_bit(FL_ALTFN) | flag_bit(FL_N), 8'h31, 8'h21, 8'h11, 8'h91,
                  8'ha1, 8'ha1);
      queue_entry(8'h7e, 13'h1fff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
      queue_entry(8'h01, 13'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      queue_key(8'h00);
      queue_key(8'h00);
      queue_key(8'h80);
      queue_key(8'h01);
      queue_key(8'h7f);
      queue_key(8'h11);
      queue_key(8'h10);
      queue_key(8'h00);
      queue_key(8'h20);
      queue_key(8'h21);
      queue_key(8'h00);
      queue_key(8'ha0);
      queue_key(8'h7e);
      settle();

      // kana with EUC prefix, repeat suppressed
      program_registers(1'b0, LK_SHIFT2, 1'b1, 1'b1);
      queue_entry(8'h30, flag_bit(FL_PUSHSH), SK_KANA, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      queue_key(8'h80);
      queue_key(8'h30);
      queue_key(8'h00);
      queue_key(8'h00);
      settle();

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase == 0)
            program_registers(1'b0, LK_NONE, 1'b0, 1'b0);
         else if (phase == 1)
            program_registers(1'b1, LK_SHIFT2, 1'b1, 1'b1);
         else
            program_registers(1'($urandom_range(0, 1)), 2'((phase - 2) % 4),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i < 16 || $urandom_range(0, 19) == 0) queue_random_entry();
            else queue_random_event();
         end
         settle();
      end

      $display("Covered %0d transfers in (%0d table writes) over %0d register settings,",
               requests_sent, table_writes, settings_used);
      $display("%0d result bytes checked, %0d mismatches", results_checked, mismatch_count);
      if (mismatch_count == 0)
         $display("PASS keyboard_scancode_encoder_top");
      else
         $display("FAIL keyboard_scancode_encoder_top");
      $finish;
   end

endmodule

// File: filelist.f
sv/kbse_pkg.sv
sv/kbse_ram.sv
sv/keyboard_scancode_encoder_top.sv
tb/keyboard_scancode_encoder_top_tb.sv
